>>> hw/rtl/lome_pkg.sv
package lome_pkg;

  // default sizing
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int LIST_LEN_RST  = 1024;

  // configuration register indexes
  localparam logic REG_LIST_LENGTH = 1'b0;

  // request command codes
  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // datapath operation codes
  localparam logic [2:0] OP_IDLE   = 3'd0;
  localparam logic [2:0] OP_SWEEP  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_UNLINK = 3'd3;
  localparam logic [2:0] OP_LINK_A = 3'd4;
  localparam logic [2:0] OP_LINK_B = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       take;
    logic       load_out;
    logic       sweep_clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_read;
    logic sweep_done;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> hw/rtl/lome_if.sv
interface lome_req_if #(
  parameter int ID_W = 11
);
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [ID_W-1:0] item_id;
  logic [ID_W-1:0] anchor_id;

  modport source (output valid, cmd, item_id, anchor_id, input ready);
  modport sink (input valid, cmd, item_id, anchor_id, output ready);
endinterface

interface lome_rsp_if #(
  parameter int ID_W = 11
);
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] next_id;
  logic            status;

  modport source (output valid, next_id, status, input ready);
  modport sink (input valid, next_id, status, output ready);
endinterface

>>> hw/rtl/lome_ram.sv
module lome_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/lome_ctrl.sv
module lome_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                cfg_we,
  input  lome_pkg::dp_stat_t  stat,
  output lome_pkg::ctrl_cmd_t cmd,
  output logic                in_ready
);

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_UNLINK = 3'd3;
  localparam logic [2:0] ST_LINK_A = 3'd4;
  localparam logic [2:0] ST_LINK_B = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE) && !stat.out_busy;

  always_comb begin
    state_next    = state;
    cmd.op        = lome_pkg::OP_IDLE;
    cmd.take      = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.sweep_clr = 1'b0;
    case (state)
      ST_SWEEP: begin
        cmd.op = lome_pkg::OP_SWEEP;
        if (stat.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.op   = lome_pkg::OP_IDLE;
        cmd.take = in_ready && in_valid;
        if (cmd.take) begin
          if (stat.bad) begin
            cmd.load_out = 1'b1;
          end else if (stat.is_read) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_UNLINK;
          end
        end
      end
      ST_READ: begin
        cmd.op = lome_pkg::OP_READ;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_UNLINK: begin
        cmd.op     = lome_pkg::OP_UNLINK;
        state_next = ST_LINK_A;
      end
      ST_LINK_A: begin
        cmd.op     = lome_pkg::OP_LINK_A;
        state_next = ST_LINK_B;
      end
      ST_LINK_B: begin
        // rewriting the same two links while stalled is harmless
        cmd.op = lome_pkg::OP_LINK_B;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
    if (cfg_we) begin
      cmd.sweep_clr = 1'b1;
      state_next    = ST_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/lome_dp.sv
module lome_dp #(
  parameter int MAX_ITEMS = 1024,
  parameter int ID_W      = 11,
  parameter int RST_LEN   = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  lome_pkg::ctrl_cmd_t cmd,
  output lome_pkg::dp_stat_t  stat,
  input  logic                cfg_we,
  input  logic [ID_W-1:0]     cfg_data,
  output logic [ID_W-1:0]     list_length,
  input  logic                in_cmd,
  input  logic [ID_W-1:0]     in_item,
  input  logic [ID_W-1:0]     in_anchor,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     out_next_id,
  output logic                out_status
);

  localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_ITEMS);
  localparam logic [ID_W-1:0] ONE_ID = ID_W'(1);

  logic [ID_W-1:0] item_q;
  logic [ID_W-1:0] anchor_q;
  logic [ID_W-1:0] p_q;
  logic [ID_W-1:0] s_q;
  logic [ID_W-1:0] after_q;
  logic [ID_W-1:0] sweep_cnt;
  logic [ID_W-1:0] len_clamped;
  logic [ID_W-1:0] after;

  logic            succ_we;
  logic [ID_W-1:0] succ_waddr;
  logic [ID_W-1:0] succ_wdata;
  logic [ID_W-1:0] succ_raddr;
  logic [ID_W-1:0] succ_rd;
  logic            pred_we;
  logic [ID_W-1:0] pred_waddr;
  logic [ID_W-1:0] pred_wdata;
  logic [ID_W-1:0] pred_raddr;
  logic [ID_W-1:0] pred_rd;

  lome_ram #(.WIDTH(ID_W), .DEPTH(MAX_ITEMS + 1)) u_succ (
    .clk   (clk),
    .we    (succ_we),
    .waddr (succ_waddr),
    .wdata (succ_wdata),
    .raddr (succ_raddr),
    .rdata (succ_rd)
  );

  lome_ram #(.WIDTH(ID_W), .DEPTH(MAX_ITEMS + 1)) u_pred (
    .clk   (clk),
    .we    (pred_we),
    .waddr (pred_waddr),
    .wdata (pred_wdata),
    .raddr (pred_raddr),
    .rdata (pred_rd)
  );

  // request checks on the live payload
  always_comb begin
    stat.is_read = (in_cmd == lome_pkg::CMD_READ);
    if (stat.is_read) begin
      stat.bad = (in_item > list_length);
    end else begin
      stat.bad = (in_item == '0) || (in_item > list_length) ||
                 (in_anchor > list_length) || (in_item == in_anchor);
    end
    stat.sweep_done = (sweep_cnt == list_length);
    stat.out_busy   = out_valid && !out_ready;
  end

  always_comb begin
    if (cfg_data == '0) begin
      len_clamped = ONE_ID;
    end else if (cfg_data > MAX_ID) begin
      len_clamped = MAX_ID;
    end else begin
      len_clamped = cfg_data;
    end
  end

  // new successor of the anchor, with the unlink write bypassed
  assign after = (anchor_q == p_q) ? s_q : succ_rd;

  always_comb begin
    succ_we    = 1'b0;
    succ_waddr = sweep_cnt;
    succ_wdata = '0;
    succ_raddr = item_q;
    pred_we    = 1'b0;
    pred_waddr = sweep_cnt;
    pred_wdata = '0;
    pred_raddr = item_q;
    case (cmd.op)
      lome_pkg::OP_IDLE: begin
        succ_raddr = in_item;
        pred_raddr = in_item;
      end
      lome_pkg::OP_SWEEP: begin
        succ_we    = 1'b1;
        succ_wdata = (sweep_cnt == list_length) ? '0 : ID_W'(sweep_cnt + ONE_ID);
        pred_we    = 1'b1;
        pred_wdata = (sweep_cnt == '0) ? list_length : ID_W'(sweep_cnt - ONE_ID);
      end
      lome_pkg::OP_READ: begin
        succ_raddr = item_q;
      end
      lome_pkg::OP_UNLINK: begin
        succ_we    = 1'b1;
        succ_waddr = pred_rd;
        succ_wdata = succ_rd;
        pred_we    = 1'b1;
        pred_waddr = succ_rd;
        pred_wdata = pred_rd;
        succ_raddr = anchor_q;
      end
      lome_pkg::OP_LINK_A: begin
        succ_we    = 1'b1;
        succ_waddr = anchor_q;
        succ_wdata = item_q;
        pred_we    = 1'b1;
        pred_waddr = item_q;
        pred_wdata = anchor_q;
      end
      lome_pkg::OP_LINK_B: begin
        succ_we    = 1'b1;
        succ_waddr = item_q;
        succ_wdata = after_q;
        pred_we    = 1'b1;
        pred_waddr = after_q;
        pred_wdata = item_q;
      end
      default: begin
        succ_we = 1'b0;
        pred_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_q   <= in_item;
      anchor_q <= in_anchor;
    end
    if (cmd.op == lome_pkg::OP_UNLINK) begin
      p_q <= pred_rd;
      s_q <= succ_rd;
    end
    if (cmd.op == lome_pkg::OP_LINK_A) begin
      after_q <= after;
    end
    if (cmd.load_out) begin
      out_next_id <= (cmd.op == lome_pkg::OP_READ) ? succ_rd : '0;
      out_status  <= (cmd.op == lome_pkg::OP_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= ID_W'(RST_LEN);
      sweep_cnt   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        list_length <= len_clamped;
      end
      if (cmd.sweep_clr) begin
        sweep_cnt <= '0;
      end else if (cmd.op == lome_pkg::OP_SWEEP && !stat.sweep_done) begin
        sweep_cnt <= ID_W'(sweep_cnt + ONE_ID);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/linked_order_move_engine.sv
// Ordered list of item ids 1..list_length kept as a doubly linked chain in two
// single-write-port tables (successor and predecessor, entry 0 as sentinel).
// A move request (cmd 0) unlinks item_id and relinks it right after anchor_id,
// or at the front for anchor 0, and answers next_id 0. A read request (cmd 1)
// answers the successor of item_id, the head for id 0, with 0 meaning end of
// list. Bad ids, or an item equal to its anchor, answer status 1 and leave the
// order alone. Steps: a move runs accept and fetch of both links, unlink and
// two relink writes, set by the chain of dependent table reads and writes
// through the one write port of each table; a read waits on the table read;
// a rejected request answers straight from its accept. One request is
// in flight at a time. After reset and after every write of list_length a
// rebuild pass of entries 0..list_length rewrites the ascending chain; req.ready
// stays low during it. list_length sits at byte address 0 of the register port.
module linked_order_move_engine #(
  parameter int MAX_ITEMS = lome_pkg::MAX_ITEMS_DEF,
  parameter int ID_W      = $clog2(MAX_ITEMS + 1)
) (
  input  logic        clk,
  input  logic        rst,
  lome_req_if.sink    req,
  lome_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // reset length is the default, limited to the table size
  localparam int RST_LEN = (MAX_ITEMS < lome_pkg::LIST_LEN_RST) ?
                           MAX_ITEMS : lome_pkg::LIST_LEN_RST;

  lome_pkg::ctrl_cmd_t cmd;
  lome_pkg::dp_stat_t  stat;
  logic                cfg_we;
  logic [ID_W-1:0]     list_length;

  // register port: no wait states, only index 0 is backed by a register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == lome_pkg::REG_LIST_LENGTH);
  assign prdata = (paddr[2] == lome_pkg::REG_LIST_LENGTH) ? 32'(list_length) : '0;

  // sequencer: rebuild pass, request intake, link update steps
  lome_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (req.ready)
  );

  // tables, captured links and the response register
  lome_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .ID_W      (ID_W),
    .RST_LEN   (RST_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_data    (pwdata[ID_W-1:0]),
    .list_length (list_length),
    .in_cmd      (req.cmd),
    .in_item     (req.item_id),
    .in_anchor   (req.anchor_id),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_next_id (rsp.next_id),
    .out_status  (rsp.status)
  );

  // a request is only taken when its response has a free slot
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> !rsp.valid || rsp.ready)
    else $error("request taken while response slot is blocked");

  // a length write starts the rebuild pass, which blocks intake
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req.ready)
    else $error("intake open right after a length write");

  // rejected requests answer in the next cycle with an error
  a_bad_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.take && stat.bad |=> rsp.valid && rsp.status)
    else $error("rejected request did not answer with an error");

  // a good move keeps intake closed for its three update steps
  a_move_busy: assert property (@(posedge clk) disable iff (rst || cfg_we)
    cmd.take && !stat.bad && !stat.is_read |=> !req.ready ##1 !req.ready ##1 !req.ready)
    else $error("intake reopened during a move");

endmodule

>>> verif/linked_order_move_engine_test.sv
`timescale 1ns / 100ps

module linked_order_move_engine_test;

  localparam int MAX_ITEMS   = lome_pkg::MAX_ITEMS_DEF;
  localparam int ID_W        = 11;
  localparam int CYCLE_LIMIT = 500000;

  // spare register index, writes to it must be ignored
  localparam logic REG_SPARE = 1'b1;

  // response status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] next_id;
    logic            status;
  } answer_t;

  typedef struct {
    logic            cmd;
    logic [ID_W-1:0] item_id;
    logic [ID_W-1:0] anchor_id;
    bit              typed;
    logic [ID_W-1:0] next_id;
    logic            status;
  } stim_row_t;

  logic clk;
  logic rst;

  // register port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lome_req_if #(.ID_W(ID_W)) req_ch ();
  lome_rsp_if #(.ID_W(ID_W)) rsp_ch ();

  linked_order_move_engine #(.MAX_ITEMS(MAX_ITEMS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the chain, entry 0 is the sentinel (head / tail)
  logic [ID_W-1:0] succ_tab [0:MAX_ITEMS];
  logic [ID_W-1:0] pred_tab [0:MAX_ITEMS];
  int              list_len;

  answer_t   expected_answers [$];
  stim_row_t directed_rows [$];

  // typed-in expectation that travels with the request on the wire
  bit              req_typed;
  logic [ID_W-1:0] req_typed_next;
  logic            req_typed_status;

  int   errors;
  int   cycle_count;
  int   burst_left;
  bit   long_stall;
  logic [ID_W-1:0] pred_next;
  logic            pred_status;
  answer_t         got_want;

  // clock and reset
  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void rebuild_chain(input int len);
    for (int i = 0; i <= MAX_ITEMS; i++) begin
      succ_tab[i] = '0;
      pred_tab[i] = '0;
    end
    for (int i = 0; i <= len; i++) begin
      succ_tab[i] = (i == len) ? '0 : ID_W'(i + 1);
      pred_tab[i] = (i == 0) ? ID_W'(len) : ID_W'(i - 1);
    end
  endfunction

  function automatic int clamp_len(input logic [31:0] value);
    int v;
    v = int'(value & 32'h7FF);
    if (v < 1) return 1;
    if (v > MAX_ITEMS) return MAX_ITEMS;
    return v;
  endfunction

  // one request against the shadow chain: answer out, chain updated on a good move
  function automatic void predict_answer(input logic c, input logic [ID_W-1:0] it,
                                         input logic [ID_W-1:0] an,
                                         output logic [ID_W-1:0] nx, output logic st);
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] s;
    logic [ID_W-1:0] after;
    nx = '0;
    st = ST_OK;
    if (c == lome_pkg::CMD_READ) begin
      if (it > list_len) st = ST_BAD;
      else nx = succ_tab[it];
    end else if (it == 0 || it > list_len || an > list_len || it == an) begin
      st = ST_BAD;
    end else begin
      // unlink
      p = pred_tab[it];
      s = succ_tab[it];
      succ_tab[p] = s;
      pred_tab[s] = p;
      // relink after the anchor, back pointer of the new successor included
      after = succ_tab[an];
      succ_tab[an] = it;
      pred_tab[it] = an;
      succ_tab[it] = after;
      pred_tab[after] = it;
    end
  endfunction

  // scoreboard: predict on request accept, compare on response accept,
  // both in one process so a same-edge accept and answer stay ordered
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        predict_answer(req_ch.cmd, req_ch.item_id, req_ch.anchor_id, pred_next, pred_status);
        if (req_typed) begin
          pred_next   = req_typed_next;
          pred_status = req_typed_status;
        end
        expected_answers.push_back('{next_id: pred_next, status: pred_status});
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: response with nothing expected, expected none, actual next_id=%0d status=%0d",
                   $time, rsp_ch.next_id, rsp_ch.status);
        end else begin
          got_want = expected_answers.pop_front();
          if (rsp_ch.next_id !== got_want.next_id) begin
            errors++;
            $display("%0t: next_id mismatch, expected %0d, actual %0d",
                     $time, got_want.next_id, rsp_ch.next_id);
          end
          if (rsp_ch.status !== got_want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, got_want.status, rsp_ch.status);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // response side: stall segments of random kind and length, plus one long hold-off
  initial begin
    int seg_len;
    int seg_kind;
    rsp_ch.ready <= 1'b0;
    forever begin
      seg_len  = $urandom_range(1, 40);
      seg_kind = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        if (long_stall) begin
          // hold off long enough for the block to back up into its request side
          rsp_ch.ready <= 1'b0;
          repeat (400) @(posedge clk);
          long_stall = 1'b0;
        end
        case (seg_kind)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ~rsp_ch.ready;
        endcase
      end
    end
  end

  // offer one request, hold it until taken, then maybe close the burst with a gap
  task automatic send_request(input logic c, input logic [ID_W-1:0] it,
                              input logic [ID_W-1:0] an, input bit typed = 1'b0,
                              input logic [ID_W-1:0] t_next = '0, input logic t_status = ST_OK);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= c;
    req_ch.item_id   <= it;
    req_ch.anchor_id <= an;
    req_typed        <= typed;
    req_typed_next   <= t_next;
    req_typed_status <= t_status;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // one edge first so a request taken at the current edge is already queued
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle and any rebuild pass over
  task automatic write_reg(input logic idx, input logic [31:0] data);
    wait_drained();
    repeat (list_len + 24) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lome_pkg::REG_LIST_LENGTH) begin
      list_len = clamp_len(data);
      rebuild_chain(list_len);
    end
  endtask

  // read back list_length, must hold the clamped value
  task automatic check_length_reg();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {lome_pkg::REG_LIST_LENGTH, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(list_len)) begin
      errors++;
      $display("%0t: list_length readback mismatch, expected %0d, actual %0d",
               $time, list_len, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input logic c, input int it, input int an, input bit typed = 1'b0,
                         input int nx = 0, input logic st = ST_OK);
    directed_rows.push_back('{cmd: c, item_id: ID_W'(it), anchor_id: ID_W'(an),
                              typed: typed, next_id: ID_W'(nx), status: st});
  endtask

  // mostly well-formed requests over the live range, the rest noise over all 11 bits
  task automatic run_random(input int count);
    int r;
    logic c;
    logic [ID_W-1:0] it;
    logic [ID_W-1:0] an;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 19);
      c = 1'($urandom_range(0, 1));
      if (r < 14) begin
        if (c == lome_pkg::CMD_READ) begin
          it = ID_W'($urandom_range(0, list_len));
          an = ID_W'($urandom());
        end else begin
          it = ID_W'($urandom_range(1, list_len));
          an = ID_W'($urandom_range(0, list_len));
        end
      end else if (r < 16) begin
        // move onto its current place
        c  = lome_pkg::CMD_MOVE;
        it = ID_W'($urandom_range(1, list_len));
        an = pred_tab[it];
      end else begin
        it = ID_W'($urandom_range(0, 2047));
        an = ID_W'($urandom_range(0, 2047));
      end
      send_request(c, it, an);
    end
  endtask

  // successor of every id, i.e. the whole order
  task automatic walk_order();
    for (int id = 0; id <= list_len; id++) send_request(lome_pkg::CMD_READ, ID_W'(id), '0);
  endtask

  initial begin
    int phase_len [10];
    phase_len = '{8, 0, 2, 2047, 5, 1, 3000, 16, 1024, 33};

    // every input known from time zero
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.cmd       <= lome_pkg::CMD_READ;
    req_ch.item_id   <= '0;
    req_ch.anchor_id <= '0;
    req_typed        <= 1'b0;
    req_typed_next   <= '0;
    req_typed_status <= ST_OK;
    errors      = 0;
    cycle_count = 0;
    burst_left  = 0;
    long_stall  = 1'b0;
    list_len    = (lome_pkg::LIST_LEN_RST > MAX_ITEMS) ? MAX_ITEMS : lome_pkg::LIST_LEN_RST;
    rebuild_chain(list_len);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, full length after reset
    add_row(lome_pkg::CMD_READ, 0, 0, 1, 1, ST_OK);          // head
    add_row(lome_pkg::CMD_READ, 1024, 0, 1, 0, ST_OK);       // tail has no successor
    add_row(lome_pkg::CMD_READ, 1025, 0, 1, 0, ST_BAD);      // just past the end
    add_row(lome_pkg::CMD_READ, 2047, 2047, 1, 0, ST_BAD);
    add_row(lome_pkg::CMD_MOVE, 0, 5, 1, 0, ST_BAD);         // item 0 is the sentinel
    add_row(lome_pkg::CMD_MOVE, 1025, 1, 1, 0, ST_BAD);
    add_row(lome_pkg::CMD_MOVE, 5, 1025, 1, 0, ST_BAD);      // anchor out of range
    add_row(lome_pkg::CMD_MOVE, 7, 7, 1, 0, ST_BAD);         // item equals anchor
    add_row(lome_pkg::CMD_MOVE, 2047, 2047, 1, 0, ST_BAD);
    add_row(lome_pkg::CMD_MOVE, 1, 0, 1, 0, ST_OK);          // already at the front
    add_row(lome_pkg::CMD_MOVE, 3, 2, 1, 0, ST_OK);          // anchor already the predecessor
    add_row(lome_pkg::CMD_READ, 2, 0, 1, 3, ST_OK);          // order unchanged
    add_row(lome_pkg::CMD_MOVE, 1024, 0, 1, 0, ST_OK);       // tail to front
    add_row(lome_pkg::CMD_READ, 0, 0);
    add_row(lome_pkg::CMD_READ, 1023, 0);
    add_row(lome_pkg::CMD_MOVE, 1, 1024);
    add_row(lome_pkg::CMD_MOVE, 500, 1023);                  // onto the tail
    add_row(lome_pkg::CMD_READ, 1023, 0);
    add_row(lome_pkg::CMD_READ, 500, 0);
    add_row(lome_pkg::CMD_MOVE, 1024, 500);
    add_row(lome_pkg::CMD_READ, 0, 0);
    add_row(lome_pkg::CMD_READ, 1024, 0);
    add_row(lome_pkg::CMD_MOVE, 1024, 0);
    add_row(lome_pkg::CMD_READ, 1365, 682, 1, 0, ST_BAD);    // alternating bit patterns
    add_row(lome_pkg::CMD_MOVE, 682, 1365, 1, 0, ST_BAD);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].item_id, directed_rows[i].anchor_id,
                   directed_rows[i].typed, directed_rows[i].next_id, directed_rows[i].status);
    end

    // random phases over several lengths, extremes and clamped values among them
    for (int k = 0; k < 10; k++) begin
      write_reg(lome_pkg::REG_LIST_LENGTH, 32'(phase_len[k]));
      check_length_reg();
      if (k == 4) write_reg(REG_SPARE, 32'd3);
      if (k == 0) long_stall = 1'b1;
      if (k == 2) begin
        // mid-phase pause until every answer is back
        run_random(16);
        wait_drained();
        run_random(16);
      end else begin
        run_random(32);
      end
      if (list_len <= 64) walk_order();
    end

    // drain, then a little slack for anything stray
    wait_drained();
    repeat (32) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
